@@ rtl/core/mtsp_pkg.sv @@
// Shared constants and types for the midtones stretch pixel map.
package mtsp_pkg;

    // Q0.16 levels, with all ones meaning 1.0.
    localparam int          LEVEL_BITS = 16;
    localparam logic [15:0] Q16_ONE    = 16'hFFFF;

    // Display channel width and the background grey.
    localparam int         PIX_BITS = 8;
    localparam logic [7:0] BG_GREY  = 8'd30;

    // Register stages inside one channel datapath: four front stages, one
    // stage per quotient bit of the clip divider, the product and sum
    // stages, and one stage per bit of the output divider.
    localparam int CH_LAT = 4 + LEVEL_BITS + 2 + PIX_BITS;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BLACK_POINT     = 2'd0,
        REG_WHITE_POINT     = 2'd1,
        REG_MIDTONE_BALANCE = 2'd2,
        REG_STRETCH_ENABLE  = 2'd3
    } cfg_reg_t;

    localparam logic [15:0] BLACK_POINT_RST     = 16'd0;
    localparam logic [15:0] WHITE_POINT_RST     = 16'hFFFF;
    localparam logic [15:0] MIDTONE_BALANCE_RST = 16'd32768;

endpackage

@@ rtl/core/mtsp_div.sv @@
// Pipelined restoring divider that settles one quotient bit per stage.
module mtsp_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              adv,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    // The quotient must fit in Q_W bits, so the shifted divisor never
    // needs more than DEN_W + Q_W bits.
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [NUM_W-1:0]  rem_reg  [Q_W-1];
    logic [DEN_W-1:0]  den_reg  [Q_W-1];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quo_in;
        logic [SIDE_W-1:0] side_k;
        logic [CW-1:0]     den_sh;
        logic              ge;
        logic [Q_W-1:0]    quo_next;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign side_k = side_in;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        assign den_sh   = CW'(den_in) << (Q_W - 1 - k);
        assign ge       = CW'(rem_in) >= den_sh;
        assign quo_next = {quo_in[Q_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_k;
            end
        end

        if (k < Q_W - 1) begin : g_keep
            logic [NUM_W-1:0] rem_next;

            assign rem_next = ge ? NUM_W'(CW'(rem_in) - den_sh) : rem_in;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo      = quo_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule

@@ rtl/core/mtsp_chan.sv @@
// Datapath of one color channel: scaling, clipping and the midtones transfer function.
module mtsp_chan #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        adv,
    input  logic [15:0] code,
    input  logic [15:0] black_point,
    input  logic [15:0] white_point,
    input  logic [15:0] midtone_balance,
    input  logic        stretch_enable,
    output logic [7:0]  pix
);

    import mtsp_pkg::*;

    localparam int          FS_INT = (1 << SAMPLE_BITS) - 1;
    localparam logic [15:0] FS     = 16'(FS_INT);
    localparam logic [17:0] FS1    = 18'(FS_INT);
    localparam logic [17:0] FS2    = 18'(2 * FS_INT);
    localparam logic [17:0] FS3    = 18'(3 * FS_INT);

    // Stage 1: saturate, form code*65535 and code*255, and estimate the
    // quotients by full scale from below with x/(2^n) + x/(2^2n).
    logic [15:0] code_sat;
    logic [31:0] xv_next;
    logic [23:0] xl_next;
    logic [32:0] vsum;
    logic [24:0] lsum;
    logic [31:0] s1_xv_reg;
    logic [23:0] s1_xl_reg;
    logic [15:0] s1_qv_reg;
    logic [7:0]  s1_ql_reg;

    assign code_sat = (code > FS) ? FS : code;
    assign xv_next  = {code_sat, 16'h0000} - {16'h0000, code_sat};
    assign xl_next  = {code_sat, 8'h00} - {8'h00, code_sat};
    assign vsum     = 33'(xv_next) + 33'(xv_next >> SAMPLE_BITS);
    assign lsum     = 25'(xl_next) + 25'(xl_next >> SAMPLE_BITS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xv_reg <= xv_next;
            s1_xl_reg <= xl_next;
            s1_qv_reg <= 16'(vsum >> SAMPLE_BITS);
            s1_ql_reg <= 8'(lsum >> SAMPLE_BITS);
        end
    end

    // Stage 2: remainders against the estimates; each is below three full scales.
    logic [31:0] vprod;
    logic [23:0] lprod;
    logic [17:0] s2_rv_reg;
    logic [17:0] s2_rl_reg;
    logic [15:0] s2_qv_reg;
    logic [7:0]  s2_ql_reg;

    assign vprod = (32'(s1_qv_reg) << SAMPLE_BITS) - 32'(s1_qv_reg);
    assign lprod = (24'(s1_ql_reg) << SAMPLE_BITS) - 24'(s1_ql_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rv_reg <= 18'(s1_xv_reg - vprod);
            s2_rl_reg <= 18'(s1_xl_reg - lprod);
            s2_qv_reg <= s1_qv_reg;
            s2_ql_reg <= s1_ql_reg;
        end
    end

    // Stage 3: correct the estimates to the exact floor.
    logic [1:0]  vcnt;
    logic [1:0]  lcnt;
    logic [15:0] s3_v_reg;
    logic [7:0]  s3_lin_reg;

    assign vcnt = {1'b0, s2_rv_reg >= FS1} + {1'b0, s2_rv_reg >= FS2}
                + {1'b0, s2_rv_reg >= FS3};
    assign lcnt = {1'b0, s2_rl_reg >= FS1} + {1'b0, s2_rl_reg >= FS2}
                + {1'b0, s2_rl_reg >= FS3};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_v_reg   <= s2_qv_reg + 16'(vcnt);
            s3_lin_reg <= s2_ql_reg + 8'(lcnt);
        end
    end

    // Stage 4: clip against black and white. Only a level strictly inside
    // the range needs the divider; the others take a fixed level.
    logic [15:0] vdiff;
    logic        need_div_next;
    logic [15:0] fixed_y_next;
    logic [31:0] s4_num_reg;
    logic [15:0] s4_den_reg;
    logic [24:0] s4_side_reg;

    assign vdiff = s3_v_reg - black_point;

    always_comb
    begin
        need_div_next = 1'b0;
        fixed_y_next  = 16'h0000;
        if (white_point > black_point)
        begin
            if (s3_v_reg <= black_point)
                fixed_y_next = 16'h0000;
            else if (s3_v_reg >= white_point)
                fixed_y_next = Q16_ONE;
            else
                need_div_next = 1'b1;
        end
        else
        begin
            // Degenerate range: a step at the black point.
            fixed_y_next = (s3_v_reg >= black_point) ? Q16_ONE : 16'h0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_num_reg  <= {vdiff, 16'h0000} - {16'h0000, vdiff};
            s4_den_reg  <= white_point - black_point;
            s4_side_reg <= {s3_lin_reg, need_div_next, fixed_y_next};
        end
    end

    logic [LEVEL_BITS-1:0] d1_quo;
    logic [24:0]           d1_side;

    mtsp_div #(
        .NUM_W  (32),
        .DEN_W  (16),
        .Q_W    (LEVEL_BITS),
        .SIDE_W (25)
    ) u_clip_div (
        .clk      (clk),
        .adv      (adv),
        .num      (s4_num_reg),
        .den      (s4_den_reg),
        .side_in  (s4_side_reg),
        .quo      (d1_quo),
        .side_out (d1_side)
    );

    // Product stage: (1-M)*y and M*(1-y), both scaled by 65535^2.
    logic [15:0] y_lvl;
    logic [15:0] m_inv;
    logic [31:0] sm_p_reg;
    logic [31:0] sm_q_reg;
    logic [7:0]  sm_lin_reg;

    assign y_lvl = d1_side[16] ? d1_quo : d1_side[15:0];
    assign m_inv = Q16_ONE - midtone_balance;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_p_reg   <= {16'h0000, m_inv} * {16'h0000, y_lvl};
            sm_q_reg   <= {16'h0000, midtone_balance} * {16'h0000, Q16_ONE - y_lvl};
            sm_lin_reg <= d1_side[24:17];
        end
    end

    // Sum stage: the denominator never exceeds 65535^2, so it fits 32 bits.
    logic [32:0] den_sum;
    logic [39:0] s5_num_reg;
    logic [31:0] s5_den_reg;
    logic [8:0]  s5_side_reg;

    assign den_sum = 33'(sm_p_reg) + 33'(sm_q_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_num_reg  <= {sm_p_reg, 8'h00} - {8'h00, sm_p_reg};
            s5_den_reg  <= den_sum[31:0];
            s5_side_reg <= {sm_lin_reg, den_sum[31:0] == 32'h0};
        end
    end

    // The numerator never exceeds 255 times the denominator, so eight
    // quotient bits hold the whole result.
    logic [PIX_BITS-1:0] d2_quo;
    logic [8:0]          d2_side;

    mtsp_div #(
        .NUM_W  (40),
        .DEN_W  (32),
        .Q_W    (PIX_BITS),
        .SIDE_W (9)
    ) u_mtf_div (
        .clk      (clk),
        .adv      (adv),
        .num      (s5_num_reg),
        .den      (s5_den_reg),
        .side_in  (s5_side_reg),
        .quo      (d2_quo),
        .side_out (d2_side)
    );

    always_comb
    begin
        if (!stretch_enable)
            pix = d2_side[8:1];
        else if (d2_side[0])
            pix = 8'h00;
        else
            pix = d2_quo;
    end

endmodule

@@ rtl/core/midtones_stretch_pixel_map.sv @@
// Top level of the midtones stretch pixel map: configuration, flow control and output register.
//
// Each transfer on the input channel carries one pixel: three sample codes and
// an in-image flag. Each transfer on the output channel carries the three 8-bit
// display channels of one pixel, in input order, one result per input pixel.
// Background pixels come out as grey 30 on all channels.
// The configuration port writes one register per cycle with cfg_write high;
// the user must change registers only while no pixel is in flight, and the
// block itself does not enforce it. Each channel datapath has 30 register
// stages, including the 16-stage clip divider and the 8-stage transfer
// function divider, and the output register follows the channel datapaths.
// Throughput is one pixel per cycle while the receiver does not stall.
// When out_valid is high and out_stall is high, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads the register defaults: black 0,
// white 65535, balance 32768 and linear scaling.
module midtones_stretch_pixel_map #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    input  logic        inside_image,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import mtsp_pkg::*;

    logic [15:0] black_point_reg;
    logic [15:0] white_point_reg;
    logic [15:0] midtone_balance_reg;
    logic        stretch_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_point_reg     <= BLACK_POINT_RST;
            white_point_reg     <= WHITE_POINT_RST;
            midtone_balance_reg <= MIDTONE_BALANCE_RST;
            stretch_enable_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLACK_POINT:     black_point_reg     <= cfg_data;
                REG_WHITE_POINT:     white_point_reg     <= cfg_data;
                REG_MIDTONE_BALANCE: midtone_balance_reg <= cfg_data;
                REG_STRETCH_ENABLE:  stretch_enable_reg  <= cfg_data[0];
            endcase
        end
    end

    // All stages move together unless a finished pixel is held at the output.
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    logic [CH_LAT-1:0] vld_reg;
    logic [CH_LAT-1:0] img_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[CH_LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[CH_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            img_reg <= {img_reg[CH_LAT-2:0], inside_image};
    end

    logic [7:0] red_pix;
    logic [7:0] green_pix;
    logic [7:0] blue_pix;

    mtsp_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_red (
        .clk             (clk),
        .adv             (adv),
        .code            (red_in),
        .black_point     (black_point_reg),
        .white_point     (white_point_reg),
        .midtone_balance (midtone_balance_reg),
        .stretch_enable  (stretch_enable_reg),
        .pix             (red_pix)
    );

    mtsp_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_green (
        .clk             (clk),
        .adv             (adv),
        .code            (green_in),
        .black_point     (black_point_reg),
        .white_point     (white_point_reg),
        .midtone_balance (midtone_balance_reg),
        .stretch_enable  (stretch_enable_reg),
        .pix             (green_pix)
    );

    mtsp_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_blue (
        .clk             (clk),
        .adv             (adv),
        .code            (blue_in),
        .black_point     (black_point_reg),
        .white_point     (white_point_reg),
        .midtone_balance (midtone_balance_reg),
        .stretch_enable  (stretch_enable_reg),
        .pix             (blue_pix)
    );

    logic [7:0] red_out_reg;
    logic [7:0] green_out_reg;
    logic [7:0] blue_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_out_reg   <= img_reg[CH_LAT-1] ? red_pix   : BG_GREY;
            green_out_reg <= img_reg[CH_LAT-1] ? green_pix : BG_GREY;
            blue_out_reg  <= img_reg[CH_LAT-1] ? blue_pix  : BG_GREY;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule

@@ test/tb_top.sv @@
// Testbench for the midtones stretch pixel map: directed and random pixels against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import mtsp_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int LONG_HOLD   = 150;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 80;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        in_image;
    } pixel_in_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        inside_image;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Copy of the register contents as the block should hold them.
    logic [15:0] cur_black;
    logic [15:0] cur_white;
    logic [15:0] cur_balance;
    logic        cur_stretch;

    pixel_out_t expected_pixels[$];
    int         mismatch_count = 0;
    int         stuck_cycles   = 0;
    bit         tx_gaps_on;
    bit         rx_stalls_on;
    bit         long_hold_req;

    midtones_stretch_pixel_map #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .inside_image(inside_image),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] map_channel(logic [15:0] code);
        longint unsigned full_scale;
        longint unsigned one;
        longint unsigned c;
        longint unsigned v;
        longint unsigned blk;
        longint unsigned wht;
        longint unsigned bal;
        longint unsigned y;
        longint unsigned num;
        longint unsigned den;
        full_scale = (64'd1 << SAMPLE_BITS) - 1;
        one = Q16_ONE;
        c = (code > full_scale) ? full_scale : code;
        if (!cur_stretch)
            return 8'((c * 255) / full_scale);
        v   = (c * one) / full_scale;
        blk = cur_black;
        wht = cur_white;
        bal = cur_balance;
        if (wht > blk)
        begin
            if (v <= blk)
                y = 0;
            else if (v >= wht)
                y = one;
            else
                y = ((v - blk) * one) / (wht - blk);
        end
        else
        begin
            // Degenerate window: a hard step at the black point.
            y = (v >= blk) ? one : 0;
        end
        num = (one - bal) * y;
        den = bal * (one - y) + y * (one - bal);
        if (den == 0)
            return 8'd0;
        num = (num * 255) / den;
        return 8'((num > 255) ? 255 : num);
    endfunction

    function automatic pixel_out_t predict_pixel(pixel_in_t px);
        pixel_out_t res;
        if (!px.in_image)
        begin
            res.red   = BG_GREY;
            res.green = BG_GREY;
            res.blue  = BG_GREY;
        end
        else
        begin
            res.red   = map_channel(px.red);
            res.green = map_channel(px.green);
            res.blue  = map_channel(px.blue);
        end
        return res;
    endfunction

    function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                         $time, red_out, green_out, blue_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_channel("red_out", want.red, red_out);
                check_channel("green_out", want.green, green_out);
                check_channel("blue_out", want.blue, blue_out);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stall bursts, or one long hold when a test asks for it.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_stalls_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one pixel and returns at the edge where the transfer happens.
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic in_image);
        pixel_in_t px;
        int        gap;
        px.red      = r;
        px.green    = g;
        px.blue     = b;
        px.in_image = in_image;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        red_in       <= r;
        green_in     <= g;
        blue_in      <= b;
        inside_image <= in_image;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pixels.insert(expected_pixels.size(), predict_pixel(px));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the registers that differ from the current contents, or all of them.
    task automatic set_regs(logic [15:0] blk, logic [15:0] wht, logic [15:0] bal,
                            logic [15:0] en_word, bit write_all);
        logic [15:0] vals [4];
        logic [15:0] olds [4];
        cfg_reg_t    idx;
        vals = '{blk, wht, bal, en_word};
        olds = '{cur_black, cur_white, cur_balance, {15'd0, cur_stretch}};
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_reg_t'(i);
            if (write_all || vals[i] != olds[i])
            begin
                cfg_write <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= vals[i];
                @(posedge clk);
                case (idx)
                    REG_BLACK_POINT:     cur_black   = vals[i];
                    REG_WHITE_POINT:     cur_white   = vals[i];
                    REG_MIDTONE_BALANCE: cur_balance = vals[i];
                    REG_STRETCH_ENABLE:  cur_stretch = vals[i][0];
                    default:             ;
                endcase
            end
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return Q16_ONE;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic set_random_regs();
        logic [15:0] blk;
        logic [15:0] wht;
        logic [15:0] tmp;
        logic [15:0] en_word;
        blk = pick_level();
        wht = pick_level();
        // Mostly a proper window; now and then an inverted or empty one.
        if (blk > wht && $urandom_range(0, 5) != 0)
        begin
            tmp = blk;
            blk = wht;
            wht = tmp;
        end
        en_word = {15'($urandom), 1'($urandom_range(0, 3) != 0)};
        set_regs(blk, wht, pick_level(), en_word, 1'b1);
    endtask

    // Codes cluster around the clip levels and the ends of the range.
    function automatic logic [15:0] pick_code();
        int base;
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'd0;
        if (k == 1)
            return Q16_ONE;
        if (k > 5)
            return 16'($urandom_range(0, 65535));
        base = (k < 4) ? int'(cur_black) : int'(cur_white);
        base = base + int'($urandom_range(0, 8)) - 4;
        if (base < 0)
            base = 0;
        if (base > 65535)
            base = 65535;
        return 16'(base);
    endfunction

    task automatic send_random_pixels(int count);
        logic [15:0] r;
        for (int i = 0; i < count; i++)
        begin
            r = pick_code();
            if ($urandom_range(0, 4) == 0)
                send_pixel(r, r, r, $urandom_range(0, 7) != 0);
            else
                send_pixel(r, pick_code(), pick_code(), $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic test_linear_mode();
        send_pixel(16'd0, 16'd0, 16'd0, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'd1, 16'd257, 16'd32768, 1'b1);
        send_pixel(16'd65534, 16'd128, 16'd255, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 16'h8000, 1'b1);
        send_pixel(16'hFFFF, 16'd0, 16'd12345, 1'b0);
    endtask

    task automatic test_stretch_cases();
        // Only the enable is written, so the other registers keep their reset values.
        set_regs(cur_black, cur_white, cur_balance, 16'd1, 1'b0);
        send_pixel(16'd0, 16'hFFFF, 16'd16384, 1'b1);
        send_pixel(16'h8001, 16'h8001, 16'h8001, 1'b1);
        send_pixel(16'd1, 16'd65534, 16'd32767, 1'b1);
        send_pixel(16'd100, 16'd200, 16'd300, 1'b0);
        // Zero balance: the denominator vanishes for a black input.
        set_regs(16'd0, Q16_ONE, 16'd0, 16'd1, 1'b0);
        send_pixel(16'd0, 16'd1, 16'hFFFF, 1'b1);
        // Full balance: the denominator vanishes for a white input.
        set_regs(16'd0, Q16_ONE, Q16_ONE, 16'd1, 1'b0);
        send_pixel(16'd0, 16'd65534, 16'hFFFF, 1'b1);
        // White below black gives a step at the black point.
        set_regs(16'd40000, 16'd20000, 16'd16384, 16'd1, 1'b0);
        send_pixel(16'd39999, 16'd40000, 16'hFFFF, 1'b1);
        set_regs(16'd30000, 16'd30000, 16'd49152, 16'd1, 1'b0);
        send_pixel(16'd29999, 16'd30000, 16'd30001, 1'b1);
        // Clipping at both ends of a proper window.
        set_regs(16'd10000, 16'd50000, 16'd20000, 16'd1, 1'b0);
        send_pixel(16'd9999, 16'd10000, 16'd30000, 1'b1);
        send_pixel(16'd50000, 16'd50001, 16'd0, 1'b1);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 11; phase++)
        begin
            set_random_regs();
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            send_random_pixels(PHASE_ITEMS);
        end
    endtask

    task automatic test_backpressure();
        set_random_regs();
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        long_hold_req = 1'b1;
        // The receiver holds off while the sender keeps offering, filling the pipeline.
        send_random_pixels(40);
        // The sender waits for every result before going on.
        drain_results();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_random_pixels(40);
    endtask

    task automatic test_steady_stream();
        set_random_regs();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_random_pixels(60);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        red_in       <= 16'd0;
        green_in     <= 16'd0;
        blue_in      <= 16'd0;
        inside_image <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_BLACK_POINT;
        cfg_data     <= 16'd0;
        cur_black     = BLACK_POINT_RST;
        cur_white     = WHITE_POINT_RST;
        cur_balance   = MIDTONE_BALANCE_RST;
        cur_stretch   = 1'b0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        long_hold_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_linear_mode();
        test_stretch_cases();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        drain_results();
        repeat (CH_LAT + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ midtones_stretch_pixel_map.f @@
rtl/core/mtsp_pkg.sv
rtl/core/mtsp_div.sv
rtl/core/mtsp_chan.sv
rtl/core/midtones_stretch_pixel_map.sv
test/tb_top.sv
